>>> hw/rtl/bilc_pkg.sv
// Package for the bitmap index list codec: widths, codes, state and
// controller/datapath command and status types. No dependencies.
package bilc_pkg;

    localparam int unsigned BILC_BITMAP_BITS = 4096;

    localparam int unsigned CMD_W      = 2;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned COUNT_W    = 13;
    localparam int unsigned ESIZE_W    = 3;
    localparam int unsigned LIMIT_W    = 13;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 13;
    localparam int unsigned ACC_W      = 32;

    localparam logic [BYTE_W-1:0]  LIST_END  = 8'hff;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 13'h1fff;

    localparam logic [ESIZE_W-1:0] RST_ELEMENT_SIZE = 3'd2;
    localparam logic [LIMIT_W-1:0] RST_BITS_IN_USE  = 13'd4096;

    typedef logic [CMD_W-1:0] t_cmd;
    localparam t_cmd CMD_CLEAR = 2'd0;
    localparam t_cmd CMD_LOAD  = 2'd1;
    localparam t_cmd CMD_EMIT  = 2'd2;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_ELEMENT_SIZE = 1'd0;
    localparam t_cfg_idx CFG_BITS_IN_USE  = 1'd1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD,
        ST_LOAD_CHK,
        ST_LOAD_WR,
        ST_EMIT,
        ST_SCAN_RD,
        ST_SCAN_CHK
    } t_state;

    typedef struct packed {
        logic byte_take;     // latch the load byte
        logic clr_cursors;   // zero cursors and counts
        logic clr_write;     // sweep one bitmap word to zero
        logic load_shift;    // shift byte into accumulator
        logic load_term_put; // list end seen on load
        logic load_rd;       // read word of the loaded index
        logic load_put;      // element complete: set bit, report
        logic scan_rd;       // read word at scan cursor
        logic scan_chk;      // look for next set bit in read word
        logic scan_term_put; // no set bit left: emit terminator
        logic emit_put;      // emit one byte of current index
    } t_dp_cmd;

    typedef struct packed {
        logic load_term;
        logic load_done;
        logic in_range;
        logic out_free;
        logic pending;
        logic scan_end;
        logic hit;
        logic clr_last;
    } t_dp_sts;

endpackage

>>> hw/rtl/bilc_in_if.sv
// Input channel of the bitmap index list codec: valid/ready plus one item.
// Depends on bilc_pkg.
interface bilc_in_if import bilc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, command, data_byte, input ready);
    modport sink   (input valid, command, data_byte, output ready);
endinterface

>>> hw/rtl/bilc_out_if.sv
// Output channel of the bitmap index list codec: valid/ready plus one result.
// Depends on bilc_pkg.
interface bilc_out_if import bilc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [BYTE_W-1:0]  out_byte;
    logic               is_terminator;
    logic [COUNT_W-1:0] element_count;
    logic               out_of_range;

    modport source (output valid, out_byte, is_terminator, element_count, out_of_range,
                    input ready);
    modport sink   (input valid, out_byte, is_terminator, element_count, out_of_range,
                    output ready);
endinterface

>>> hw/rtl/bilc_datapath.sv
// Datapath: config registers, load/emit cursors, word-wide bitmap memory,
// next-set-bit search and the output register. Depends on bilc_pkg.
module bilc_datapath import bilc_pkg::*; #(
    parameter int unsigned BITMAP_BITS = BILC_BITMAP_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts,
    input  logic [BYTE_W-1:0]     i_data_byte,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [BYTE_W-1:0]     o_out_byte,
    output logic                  o_is_terminator,
    output logic [COUNT_W-1:0]    o_element_count,
    output logic                  o_out_of_range
);

    localparam int unsigned IDX_W     = $clog2(BITMAP_BITS);
    localparam int unsigned SCAN_W    = IDX_W + 1;
    localparam int unsigned WORD_BITS = (BITMAP_BITS >= 32) ? 32 : 8;
    localparam int unsigned WB        = $clog2(WORD_BITS);
    localparam int unsigned NUM_WORDS = (BITMAP_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int unsigned WA        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int unsigned CMP_W     = (SCAN_W > LIMIT_W) ? SCAN_W : LIMIT_W;

    // configuration
    logic [ESIZE_W-1:0] r_esize;
    logic [LIMIT_W-1:0] r_bits_in_use;

    // load side
    logic [BYTE_W-1:0]  r_byte;
    logic [ACC_W-1:0]   r_acc;
    logic [1:0]         r_load_pos;
    logic [COUNT_W-1:0] r_load_cnt;

    // emit side
    logic [SCAN_W-1:0]  r_scan;
    logic [1:0]         r_emit_pos;
    logic [IDX_W-1:0]   r_cur_idx;
    logic [COUNT_W-1:0] r_emit_cnt;
    logic               r_pending;

    // bitmap memory
    logic [WA-1:0]        r_clr_addr;
    logic [WORD_BITS-1:0] r_mem [NUM_WORDS];
    logic [WORD_BITS-1:0] r_rd_data;

    // output register
    logic               r_out_valid;
    logic [BYTE_W-1:0]  r_out_byte;
    logic               r_out_term;
    logic [COUNT_W-1:0] r_out_cnt;
    logic               r_out_oor;

    logic [ESIZE_W-1:0]   s_eff;
    logic [1:0]           load_pos_inc;
    logic                 load_term;
    logic                 load_done;
    logic [ACC_W-1:0]     acc_next;
    logic                 acc_in_range;
    logic [IDX_W-1:0]     acc_idx;
    logic [WA-1:0]        acc_word;
    logic [WB-1:0]        acc_bit;
    logic [CMP_W-1:0]     lim;
    logic                 scan_end;
    logic [WA-1:0]        scan_word;
    logic [WB-1:0]        scan_off;
    logic [SCAN_W-1:0]    word_base;
    logic [SCAN_W-1:0]    next_word;
    logic [WORD_BITS-1:0] masked;
    logic                 found;
    logic [WB-1:0]        fbit;
    logic [SCAN_W-1:0]    hit_pos;
    logic                 hit;
    logic [2:0]           ep3;
    logic [2:0]           ep_inc;
    logic                 emit_last;
    logic [1:0]           byte_sel;
    logic [ACC_W-1:0]     idx32;
    logic [BYTE_W-1:0]    emit_byte;
    logic                 out_free;
    logic                 any_put;
    logic                 mem_we;
    logic [WA-1:0]        mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic                 mem_re;
    logic [WA-1:0]        mem_raddr;

    always_comb begin
        if (r_esize == 3'd0) begin
            s_eff = 3'd1;
        end else if (r_esize > 3'd4) begin
            s_eff = 3'd4;
        end else begin
            s_eff = r_esize;
        end
    end

    // load decode
    assign load_term    = (r_load_pos == 2'd0) && (r_byte == LIST_END);
    assign load_pos_inc = r_load_pos + 2'd1;
    assign load_done    = (load_pos_inc == 2'd0) || ({1'b0, load_pos_inc} >= s_eff);
    assign acc_next     = {r_acc[ACC_W-BYTE_W-1:0], r_byte};
    assign acc_in_range = r_acc < ACC_W'(BITMAP_BITS);
    assign acc_idx      = r_acc[IDX_W-1:0];
    assign acc_word     = WA'(acc_idx >> WB);
    assign acc_bit      = acc_idx[WB-1:0];

    // scan decode
    always_comb begin
        if (CMP_W'(r_bits_in_use) > CMP_W'(BITMAP_BITS)) begin
            lim = CMP_W'(BITMAP_BITS);
        end else begin
            lim = CMP_W'(r_bits_in_use);
        end
    end

    assign scan_end  = CMP_W'(r_scan) >= lim;
    assign scan_word = WA'(r_scan >> WB);
    assign scan_off  = r_scan[WB-1:0];
    assign word_base = {r_scan[SCAN_W-1:WB], {WB{1'b0}}};
    assign next_word = word_base + SCAN_W'(WORD_BITS);
    assign masked    = r_rd_data & ({WORD_BITS{1'b1}} << scan_off);

    // lowest set bit at or above the cursor within the word
    always_comb begin
        found = 1'b0;
        fbit  = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (masked[i]) begin
                found = 1'b1;
                fbit  = WB'(i);
            end
        end
    end

    assign hit_pos = word_base + SCAN_W'(fbit);
    // a set bit at or past the limit means nothing is left below it
    assign hit     = found && (CMP_W'(hit_pos) < lim);

    // emit byte select; a position past the size gives the low byte
    assign ep3       = {1'b0, r_emit_pos};
    assign ep_inc    = ep3 + 3'd1;
    assign emit_last = ep_inc >= s_eff;
    assign byte_sel  = (ep3 < s_eff) ? 2'(s_eff - 3'd1 - ep3) : 2'd0;
    assign idx32     = ACC_W'(r_cur_idx);
    assign emit_byte = idx32[{byte_sel, 3'b000} +: BYTE_W];

    assign out_free = !r_out_valid || i_out_ready;
    assign any_put  = i_cmd.load_term_put || i_cmd.load_put
                   || i_cmd.scan_term_put || i_cmd.emit_put;

    // memory ports
    assign mem_we    = i_cmd.clr_write || (i_cmd.load_put && acc_in_range);
    assign mem_waddr = i_cmd.clr_write ? r_clr_addr : acc_word;
    assign mem_wdata = i_cmd.clr_write ? '0 : (r_rd_data | (WORD_BITS'(1) << acc_bit));
    assign mem_re    = i_cmd.load_rd || i_cmd.scan_rd;
    assign mem_raddr = i_cmd.load_rd ? acc_word : scan_word;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esize       <= RST_ELEMENT_SIZE;
            r_bits_in_use <= RST_BITS_IN_USE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ELEMENT_SIZE: r_esize       <= i_cfg_data[ESIZE_W-1:0];
                CFG_BITS_IN_USE:  r_bits_in_use <= i_cfg_data[LIMIT_W-1:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.byte_take) begin
            r_byte <= i_data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_write) begin
            r_clr_addr <= (r_clr_addr == WA'(NUM_WORDS - 1)) ? '0 : r_clr_addr + WA'(1);
        end
    end

    // cursors and counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clr_cursors) begin
            r_acc      <= '0;
            r_load_pos <= '0;
            r_load_cnt <= '0;
            r_scan     <= '0;
            r_emit_pos <= '0;
            r_cur_idx  <= '0;
            r_emit_cnt <= '0;
            r_pending  <= 1'b0;
        end else begin
            if (i_cmd.load_term_put) begin
                r_load_cnt <= '0;
                r_acc      <= '0;
            end
            if (i_cmd.load_shift) begin
                r_acc      <= acc_next;
                r_load_pos <= load_pos_inc;
            end
            if (i_cmd.load_put) begin
                r_load_cnt <= (r_load_cnt >= COUNT_MAX) ? COUNT_MAX
                                                        : r_load_cnt + COUNT_W'(1);
                r_acc      <= '0;
                r_load_pos <= '0;
            end
            if (i_cmd.scan_term_put) begin
                r_scan     <= '0;
                r_emit_cnt <= '0;
                r_emit_pos <= '0;
            end
            if (i_cmd.scan_chk) begin
                if (hit) begin
                    r_cur_idx  <= hit_pos[IDX_W-1:0];
                    r_scan     <= hit_pos + SCAN_W'(1);
                    r_emit_pos <= '0;
                    r_pending  <= 1'b1;
                    r_emit_cnt <= (r_emit_cnt >= COUNT_MAX) ? COUNT_MAX
                                                            : r_emit_cnt + COUNT_W'(1);
                end else begin
                    r_scan <= next_word;
                end
            end
            if (i_cmd.emit_put) begin
                if (emit_last) begin
                    r_emit_pos <= '0;
                    r_pending  <= 1'b0;
                end else begin
                    r_emit_pos <= ep_inc[1:0];
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (any_put) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        priority if (i_cmd.load_term_put) begin
            r_out_byte <= LIST_END;
            r_out_term <= 1'b1;
            r_out_cnt  <= r_load_cnt;
            r_out_oor  <= 1'b0;
        end else if (i_cmd.load_put) begin
            r_out_byte <= '0;
            r_out_term <= 1'b0;
            r_out_cnt  <= '0;
            r_out_oor  <= !acc_in_range;
        end else if (i_cmd.scan_term_put) begin
            r_out_byte <= LIST_END;
            r_out_term <= 1'b1;
            r_out_cnt  <= r_emit_cnt;
            r_out_oor  <= 1'b0;
        end else if (i_cmd.emit_put) begin
            r_out_byte <= emit_byte;
            r_out_term <= 1'b0;
            r_out_cnt  <= '0;
            r_out_oor  <= 1'b0;
        end else begin
            r_out_byte <= r_out_byte;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_byte      = r_out_byte;
    assign o_is_terminator = r_out_term;
    assign o_element_count = r_out_cnt;
    assign o_out_of_range  = r_out_oor;

    assign o_sts.load_term = load_term;
    assign o_sts.load_done = load_done;
    assign o_sts.in_range  = acc_in_range;
    assign o_sts.out_free  = out_free;
    assign o_sts.pending   = r_pending;
    assign o_sts.scan_end  = scan_end;
    assign o_sts.hit       = hit;
    assign o_sts.clr_last  = (r_clr_addr == WA'(NUM_WORDS - 1));

endmodule

>>> hw/rtl/bilc_ctrl.sv
// Controller state machine: accepts items, sequences clear sweep, load
// read-modify-write and emit scan. Depends on bilc_pkg.
module bilc_ctrl import bilc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_cmd    i_in_cmd,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign accept = i_in_valid && (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (i_sts.clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (accept) begin
                    unique case (i_in_cmd)
                        CMD_CLEAR: n_state = ST_CLEAR;
                        CMD_LOAD:  n_state = ST_LOAD;
                        CMD_EMIT:  n_state = ST_EMIT;
                        default:   n_state = ST_IDLE;
                    endcase
                end
            end
            ST_LOAD: begin
                if (i_sts.load_term) begin
                    if (i_sts.out_free) n_state = ST_IDLE;
                end else if (i_sts.load_done) begin
                    n_state = ST_LOAD_CHK;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_LOAD_CHK: begin
                if (i_sts.in_range) begin
                    n_state = ST_LOAD_WR;
                end else if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_LOAD_WR: begin
                if (i_sts.out_free) n_state = ST_IDLE;
            end
            ST_EMIT: begin
                if (!i_sts.pending) begin
                    n_state = ST_SCAN_RD;
                end else if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_SCAN_RD: begin
                if (!i_sts.scan_end) begin
                    n_state = ST_SCAN_CHK;
                end else if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_SCAN_CHK: begin
                n_state = i_sts.hit ? ST_EMIT : ST_SCAN_RD;
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_CLEAR: o_cmd.clr_write = 1'b1;
            ST_IDLE: begin
                o_in_ready        = 1'b1;
                o_cmd.clr_cursors = accept && (i_in_cmd == CMD_CLEAR);
                o_cmd.byte_take   = accept && (i_in_cmd == CMD_LOAD);
            end
            ST_LOAD: begin
                if (i_sts.load_term) begin
                    o_cmd.load_term_put = i_sts.out_free;
                end else begin
                    o_cmd.load_shift = 1'b1;
                end
            end
            ST_LOAD_CHK: begin
                if (i_sts.in_range) begin
                    o_cmd.load_rd = 1'b1;
                end else begin
                    o_cmd.load_put = i_sts.out_free;
                end
            end
            ST_LOAD_WR: o_cmd.load_put = i_sts.out_free;
            ST_EMIT:    o_cmd.emit_put = i_sts.pending && i_sts.out_free;
            ST_SCAN_RD: begin
                if (i_sts.scan_end) begin
                    o_cmd.scan_term_put = i_sts.out_free;
                end else begin
                    o_cmd.scan_rd = 1'b1;
                end
            end
            ST_SCAN_CHK: o_cmd.scan_chk = 1'b1;
            default: o_cmd = '0;
        endcase
    end

endmodule

>>> hw/rtl/bitmap_index_list_codec_unit.sv
// Bitmap index list codec, top level. A load byte that completes an in-range element adds
// a bitmap word read-modify-write; an out-of-range element is reported without one. An emit
// byte of an index under way needs no search; a byte that starts a new index, or the
// terminator, first searches the bitmap one 32-bit word at a time. The word search and the
// output slot set the rate. Clear and reset sweep the bitmap one word a cycle (128 words at 4096
// bits), with no item accepted meanwhile; reset also restores element_size 2, bits_in_use 4096.
module bitmap_index_list_codec_unit import bilc_pkg::*; #(
    parameter int unsigned BITMAP_BITS = BILC_BITMAP_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    bilc_in_if.sink               i_in_ch,
    bilc_out_if.source            o_out_ch,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd s_cmd;
    t_dp_sts s_sts;

    bilc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_ch.valid),
        .i_in_cmd   (i_in_ch.command),
        .o_in_ready (i_in_ch.ready),
        .i_sts      (s_sts),
        .o_cmd      (s_cmd)
    );

    bilc_datapath #(
        .BITMAP_BITS (BITMAP_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (s_cmd),
        .o_sts           (s_sts),
        .i_data_byte     (i_in_ch.data_byte),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_out_ready     (o_out_ch.ready),
        .o_out_valid     (o_out_ch.valid),
        .o_out_byte      (o_out_ch.out_byte),
        .o_is_terminator (o_out_ch.is_terminator),
        .o_element_count (o_out_ch.element_count),
        .o_out_of_range  (o_out_ch.out_of_range)
    );

    // a result never lands on a held one
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_cmd.load_term_put || s_cmd.load_put || s_cmd.scan_term_put || s_cmd.emit_put)
        |-> !(o_out_ch.valid && !o_out_ch.ready))
        else $error("result issued while output slot occupied");

    a_one_put: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({s_cmd.load_term_put, s_cmd.load_put, s_cmd.scan_term_put, s_cmd.emit_put}))
        else $error("more than one result issued in a cycle");

    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_ch.valid && i_in_ch.ready && i_in_ch.command == CMD_CLEAR) |=> !i_in_ch.ready)
        else $error("item accepted at start of clear sweep");

    a_term_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_ch.valid && o_out_ch.is_terminator) |-> (o_out_ch.out_byte == LIST_END))
        else $error("terminator without list end byte");

endmodule
